[hw/rtl/tfl_pkg.sv]
// shared constants for the triangle light flux datapath
// no dependencies

package tfl_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   localparam int GAIN_WIDTH = 32;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 32'h0001_0000;

   localparam int FLUX_WIDTH   = 63;
   localparam int STATUS_WIDTH = 2;
   localparam int QUO_BITS     = FLUX_WIDTH;

   // width of one partial-product slice in the multipliers
   localparam int MUL_LIMB = 32;

   localparam logic [STATUS_WIDTH-1:0] STATUS_LIT        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FACING_AWAY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DEGENERATE  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SATURATED   = 2'd3;

endpackage

[hw/rtl/tfl_mul.sv]
// pipelined unsigned multiplier, one 32 by 32 partial product per stage
// depends on tfl_pkg

module tfl_mul #(
   parameter int AW = 32,
   parameter int BW = 64
) (
   input  logic            clock,
   input  logic            en,
   input  logic [AW-1:0]   a,
   input  logic [BW-1:0]   b,
   output logic [AW+BW-1:0] p
);
   import tfl_pkg::*;

   localparam int NLA = (AW + MUL_LIMB - 1) / MUL_LIMB;
   localparam int NLB = (BW + MUL_LIMB - 1) / MUL_LIMB;
   localparam int NS  = NLA * NLB;
   localparam int APW = NLA * MUL_LIMB;
   localparam int BPW = NLB * MUL_LIMB;
   localparam int PW  = APW + BPW;
   localparam int PPW = 2 * MUL_LIMB;

   logic [APW-1:0] a_pad;
   logic [BPW-1:0] b_pad;
   logic [APW-1:0] a_ff   [NS-1];
   logic [BPW-1:0] b_ff   [NS-1];
   logic [PW-1:0]  acc_ff [NS];
   logic [APW-1:0] a_st   [NS];
   logic [BPW-1:0] b_st   [NS];
   logic [PW-1:0]  acc_st [NS];
   logic [PPW-1:0] part   [NS];

   assign a_pad = APW'(a);
   assign b_pad = BPW'(b);

   // stage k works on slice (k mod NLA) of a and slice (k div NLA) of b
   always_comb begin
      a_st[0]   = a_pad;
      b_st[0]   = b_pad;
      acc_st[0] = '0;
      for (int k = 1; k < NS; k++) begin
         a_st[k]   = a_ff[k-1];
         b_st[k]   = b_ff[k-1];
         acc_st[k] = acc_ff[k-1];
      end
      for (int ib = 0; ib < NLB; ib++) begin
         for (int ia = 0; ia < NLA; ia++) begin
            part[ib*NLA+ia] = PPW'(a_st[ib*NLA+ia][ia*MUL_LIMB +: MUL_LIMB])
                            * PPW'(b_st[ib*NLA+ia][ib*MUL_LIMB +: MUL_LIMB]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= a_pad;
         b_ff[0] <= b_pad;
         for (int k = 1; k < NS - 1; k++) begin
            a_ff[k] <= a_ff[k-1];
            b_ff[k] <= b_ff[k-1];
         end
         for (int ib = 0; ib < NLB; ib++) begin
            for (int ia = 0; ia < NLA; ia++) begin
               acc_ff[ib*NLA+ia] <= acc_st[ib*NLA+ia]
                                  + (PW'(part[ib*NLA+ia]) << ((ia + ib) * MUL_LIMB));
            end
         end
      end
   end

   assign p = acc_ff[NS-1][AW+BW-1:0];

endmodule

[hw/rtl/tfl_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow check
// depends on tfl_pkg

module tfl_div #(
   parameter int NUMW = 64,
   parameter int DENW = 32
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [NUMW-1:0]              num,
   input  logic [DENW-1:0]              den,
   output logic [tfl_pkg::QUO_BITS-1:0] quo,
   output logic                         sat
);
   import tfl_pkg::*;

   localparam int QB   = QUO_BITS;
   localparam int CMPW = (NUMW > DENW + QB) ? NUMW + 1 : DENW + QB + 1;

   logic [NUMW-1:0] rem_ff [QB];
   logic [DENW-1:0] den_ff [QB];
   logic [QB-1:0]   q_ff   [QB+1];
   logic            sat_ff [QB+1];
   logic [CMPW-1:0] trial  [QB];
   logic [QB-1:0]   take;

   // trial subtract of den shifted to the bit under test
   always_comb begin
      for (int j = 0; j < QB; j++) begin
         trial[j] = CMPW'(rem_ff[j]) - (CMPW'(den_ff[j]) << (QB - 1 - j));
         take[j]  = ~trial[j][CMPW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // quotient of 2^QB or more saturates (also covers den of zero)
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= (CMPW'(num) >= (CMPW'(den) << QB));
         for (int j = 1; j <= QB; j++) begin
            q_ff[j]   <= q_ff[j-1] | (QB'(take[j-1]) << (QB - j));
            sat_ff[j] <= sat_ff[j-1];
         end
         for (int j = 1; j < QB; j++) begin
            rem_ff[j] <= take[j-1] ? NUMW'(trial[j-1]) : rem_ff[j-1];
            den_ff[j] <= den_ff[j-1];
         end
      end
   end

   assign quo = q_ff[QB];
   assign sat = sat_ff[QB];

endmodule

[hw/rtl/triangle_facing_light_flux_core.sv]
// triangle light flux from the +y direction, top level
// depends on tfl_pkg, tfl_mul, tfl_div
//
// usage
//  - req_ channel: one triangle per transaction (vertices a, b, c, signed
//    fixed point with FRAC_BITS fraction bits)
//  - rsp_ channel: one transaction per triangle, flux (unsigned, saturating)
//    and status (lit, facing away, degenerate, saturated), in order
//  - csr_wr_en / csr_wr_data write the gain register; write only while idle
//  - normal n = (a-b) x (b-c) is exact; flux = floor(gain*ny^3 /
//    (2^(2*FRAC_BITS+1) * |n|^2)), the projected area times ny_unit^2
//  - pipeline: edge vector, cross product, normal and magnitude stages, then the
//    square, cube and gain multipliers, one 32x32 partial product per stage,
//    the divider, one quotient bit per stage, and the output register
//  - throughput: one transaction per cycle unless a receiver stall holds the
//    pipe; every stage registered
//  - reset clears the valid bits of all stages and sets gain to 1.0
//  - receiver stall: the whole pipe holds while the output register is full
//    and rsp_ready is low; nothing is dropped or repeated, and bubbles
//    ahead of the output still fill while the output is empty

module triangle_facing_light_flux_core #(
   parameter int COORD_WIDTH = tfl_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = tfl_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfl_pkg::GAIN_WIDTH-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_a_x,
   input  logic signed [COORD_WIDTH-1:0]       req_a_y,
   input  logic signed [COORD_WIDTH-1:0]       req_a_z,
   input  logic signed [COORD_WIDTH-1:0]       req_b_x,
   input  logic signed [COORD_WIDTH-1:0]       req_b_y,
   input  logic signed [COORD_WIDTH-1:0]       req_b_z,
   input  logic signed [COORD_WIDTH-1:0]       req_c_x,
   input  logic signed [COORD_WIDTH-1:0]       req_c_y,
   input  logic signed [COORD_WIDTH-1:0]       req_c_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tfl_pkg::FLUX_WIDTH-1:0]      rsp_flux,
   output logic [tfl_pkg::STATUS_WIDTH-1:0]    rsp_status
);
   import tfl_pkg::*;

   // datapath widths
   localparam int DW   = COORD_WIDTH + 1;      // edge vector component
   localparam int PW   = 2 * DW;               // cross product term
   localparam int NW   = PW + 1;               // normal component, signed
   localparam int NM   = NW - 1;               // normal magnitude
   localparam int SQW  = 2 * NM;               // squared component
   localparam int LW   = SQW + 2;              // |n|^2
   localparam int CUW  = SQW + NM;             // ny^3
   localparam int NUMW = CUW + GAIN_WIDTH;     // gain * ny^3
   localparam int SH   = 2 * FRAC_BITS + 1;
   localparam int DENW = LW + SH;              // |n|^2 * 2^SH

   // pipeline depths of the multipliers, one partial product per stage
   localparam int NLS = (NM + MUL_LIMB - 1) / MUL_LIMB;
   localparam int LS  = NLS * NLS;
   localparam int LC  = ((SQW + MUL_LIMB - 1) / MUL_LIMB) * NLS;
   localparam int LG  = ((GAIN_WIDTH + MUL_LIMB - 1) / MUL_LIMB)
                      * ((CUW + MUL_LIMB - 1) / MUL_LIMB);
   localparam int DEN_DLY  = LC + LG - 1;
   localparam int FLAG_DLY = LS + LC + LG + QUO_BITS + 1;
   localparam int NV = 6 + LS + LC + LG + QUO_BITS;

   logic en;
   logic [NV-1:0] vld_ff;
   logic [GAIN_WIDTH-1:0] gain_ff;

   // stage 1: edge vectors
   logic signed [DW-1:0] v1x_ff, v1y_ff, v1z_ff, v2x_ff, v2y_ff, v2z_ff;
   // stage 2: cross product terms
   logic signed [PW-1:0] txp_ff, txm_ff, typ_ff, tym_ff, tzp_ff, tzm_ff;
   // stage 3: normal
   logic signed [NW-1:0] nx_ff, ny_ff, nz_ff;
   // stage 4: magnitudes and flags
   logic [NM-1:0] nx_abs_ff, ny_pos_ff, nz_abs_ff;
   logic degen_ff, away_ff;

   logic [SQW-1:0] sq_x, sq_y, sq_z;
   logic [NM-1:0]  ny_dly_ff [LS];
   logic [LW-1:0]  len2_ff;
   logic [LW-1:0]  len2_dly_ff [DEN_DLY];
   logic [CUW-1:0] cube;
   logic [NUMW-1:0] num;
   logic [QUO_BITS-1:0] quo;
   logic sat;
   logic [1:0] flag_dly_ff [FLAG_DLY];

   logic [FLUX_WIDTH-1:0]   flux_in;
   logic [STATUS_WIDTH-1:0] status_in;

   // everything moves together unless a finished result is stuck at the output
   assign en        = ~vld_ff[NV-1] | rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1x_ff <= DW'(req_a_x) - DW'(req_b_x);
         v1y_ff <= DW'(req_a_y) - DW'(req_b_y);
         v1z_ff <= DW'(req_a_z) - DW'(req_b_z);
         v2x_ff <= DW'(req_b_x) - DW'(req_c_x);
         v2y_ff <= DW'(req_b_y) - DW'(req_c_y);
         v2z_ff <= DW'(req_b_z) - DW'(req_c_z);

         txp_ff <= PW'(v1y_ff) * PW'(v2z_ff);
         txm_ff <= PW'(v1z_ff) * PW'(v2y_ff);
         typ_ff <= PW'(v1z_ff) * PW'(v2x_ff);
         tym_ff <= PW'(v1x_ff) * PW'(v2z_ff);
         tzp_ff <= PW'(v1x_ff) * PW'(v2y_ff);
         tzm_ff <= PW'(v1y_ff) * PW'(v2x_ff);

         nx_ff <= NW'(txp_ff) - NW'(txm_ff);
         ny_ff <= NW'(typ_ff) - NW'(tym_ff);
         nz_ff <= NW'(tzp_ff) - NW'(tzm_ff);

         // a facing-away normal feeds zero into the flux math
         nx_abs_ff <= nx_ff[NW-1] ? NM'(-nx_ff) : NM'(nx_ff);
         nz_abs_ff <= nz_ff[NW-1] ? NM'(-nz_ff) : NM'(nz_ff);
         ny_pos_ff <= ny_ff[NW-1] ? '0 : NM'(ny_ff);
         degen_ff  <= (nx_ff == '0) && (ny_ff == '0) && (nz_ff == '0);
         away_ff   <= ny_ff[NW-1];

         ny_dly_ff[0] <= ny_pos_ff;
         for (int i = 1; i < LS; i++) begin
            ny_dly_ff[i] <= ny_dly_ff[i-1];
         end

         len2_ff <= LW'(sq_x) + LW'(sq_y) + LW'(sq_z);
         len2_dly_ff[0] <= len2_ff;
         for (int i = 1; i < DEN_DLY; i++) begin
            len2_dly_ff[i] <= len2_dly_ff[i-1];
         end

         flag_dly_ff[0] <= {degen_ff, away_ff};
         for (int i = 1; i < FLAG_DLY; i++) begin
            flag_dly_ff[i] <= flag_dly_ff[i-1];
         end
      end
   end

   // squares of the normal components
   tfl_mul #(.AW(NM), .BW(NM)) u_sq_x (
      .clock(clock), .en(en), .a(nx_abs_ff), .b(nx_abs_ff), .p(sq_x));
   tfl_mul #(.AW(NM), .BW(NM)) u_sq_y (
      .clock(clock), .en(en), .a(ny_pos_ff), .b(ny_pos_ff), .p(sq_y));
   tfl_mul #(.AW(NM), .BW(NM)) u_sq_z (
      .clock(clock), .en(en), .a(nz_abs_ff), .b(nz_abs_ff), .p(sq_z));

   // ny^3, then times gain
   tfl_mul #(.AW(SQW), .BW(NM)) u_cube (
      .clock(clock), .en(en), .a(sq_y), .b(ny_dly_ff[LS-1]), .p(cube));
   tfl_mul #(.AW(GAIN_WIDTH), .BW(CUW)) u_gain (
      .clock(clock), .en(en), .a(gain_ff), .b(cube), .p(num));

   tfl_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
      .clock(clock),
      .en   (en),
      .num  (num),
      .den  ({len2_dly_ff[DEN_DLY-1], {SH{1'b0}}}),
      .quo  (quo),
      .sat  (sat)
   );

   // status priority: degenerate, then facing away, then saturation
   always_comb begin
      if (flag_dly_ff[FLAG_DLY-1][1]) begin
         status_in = STATUS_DEGENERATE;
         flux_in   = '0;
      end else if (flag_dly_ff[FLAG_DLY-1][0]) begin
         status_in = STATUS_FACING_AWAY;
         flux_in   = '0;
      end else if (sat) begin
         status_in = STATUS_SATURATED;
         flux_in   = '1;
      end else begin
         status_in = STATUS_LIT;
         flux_in   = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_flux   <= flux_in;
         rsp_status <= status_in;
      end
   end

endmodule

[verif/tb_triangle_facing_light_flux_core.sv]
// testbench for triangle_facing_light_flux_core: directed table plus random triangles
// depends on tfl_pkg and the rtl of the block; a typed expectation or its own flux predictor checks every response
`timescale 1ns / 1ps

module tb_triangle_facing_light_flux_core;
   import tfl_pkg::*;

   localparam int CW          = DEF_COORD_WIDTH;
   localparam int PIPE_DEPTH  = 100;
   localparam int N_RANDOM    = 1620;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_type;

   typedef struct packed {
      logic [FLUX_WIDTH-1:0]   flux;
      logic [STATUS_WIDTH-1:0] status;
   } light_type;

   typedef struct {
      triangle_type shape;
      bit           typed;
      light_type    want;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [GAIN_WIDTH-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   triangle_type tri_drv = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [FLUX_WIDTH-1:0] rsp_flux;
   logic [STATUS_WIDTH-1:0] rsp_status;

   light_type flux_queue[$];
   logic [GAIN_WIDTH-1:0] gain_shadow = GAIN_RESET;
   int      n_errors = 0;
   int      n_sent = 0;
   int      n_checked = 0;
   int      n_sat = 0;
   int      n_away = 0;
   int      n_degen = 0;
   longint  cycles = 0;

   triangle_facing_light_flux_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_a_x     (tri_drv.ax),
      .req_a_y     (tri_drv.ay),
      .req_a_z     (tri_drv.az),
      .req_b_x     (tri_drv.bx),
      .req_b_y     (tri_drv.by),
      .req_b_z     (tri_drv.bz),
      .req_c_x     (tri_drv.cx),
      .req_c_y     (tri_drv.cy),
      .req_c_z     (tri_drv.cz),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_flux    (rsp_flux),
      .rsp_status  (rsp_status)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // flux predictor: exact normal, then floor(gain*ny^3 / (2^33 * |n|^2))
   function automatic light_type predict_flux(input triangle_type t,
                                              input logic [GAIN_WIDTH-1:0] g);
      logic signed [159:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, norm2;
      logic [319:0] nyw, num, den, quo;
      light_type r;
      e1x = 160'(t.ax) - 160'(t.bx);
      e1y = 160'(t.ay) - 160'(t.by);
      e1z = 160'(t.az) - 160'(t.bz);
      e2x = 160'(t.bx) - 160'(t.cx);
      e2y = 160'(t.by) - 160'(t.cy);
      e2z = 160'(t.bz) - 160'(t.cz);
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      norm2 = nx * nx + ny * ny + nz * nz;
      r.flux = '0;
      if (norm2 == 0) begin
         r.status = STATUS_DEGENERATE;
      end else if (ny < 0) begin
         r.status = STATUS_FACING_AWAY;
      end else begin
         nyw = 320'(ny);
         num = nyw * nyw * nyw * 320'(g);
         den = 320'(norm2) << (2 * DEF_FRAC_BITS + 1);
         quo = num / den;
         if (quo >= (320'd1 << FLUX_WIDTH)) begin
            r.flux = '1;
            r.status = STATUS_SATURATED;
         end else begin
            r.flux = quo[FLUX_WIDTH-1:0];
            r.status = STATUS_LIT;
         end
      end
      return r;
   endfunction

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d responses outstanding",
                  $realtime, cycles, flux_queue.size());
         $display("tb_triangle_facing_light_flux_core failed");
         $finish;
      end
   end

   // response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin
      light_type exp_l;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flux_queue.size() == 0) begin
            $display("%0t unexpected response flux=%0d status=%0d",
                     $realtime, rsp_flux, rsp_status);
            n_errors++;
         end else begin
            exp_l = flux_queue.pop_front();
            n_checked++;
            case (exp_l.status)
               STATUS_SATURATED:   n_sat++;
               STATUS_FACING_AWAY: n_away++;
               STATUS_DEGENERATE:  n_degen++;
               default: ;
            endcase
            if (rsp_flux !== exp_l.flux) begin
               $display("%0t flux mismatch expected %0d actual %0d",
                        $realtime, exp_l.flux, rsp_flux);
               n_errors++;
            end
            if (rsp_status !== exp_l.status) begin
               $display("%0t status mismatch expected %0d actual %0d",
                        $realtime, exp_l.status, rsp_status);
               n_errors++;
            end
         end
      end
   end

   // receiver: random stalls with calm stretches, plus one long hold-off
   // once traffic is flowing so the pipe backs up into req_ready
   initial begin
      int r;
      int ncyc;
      bit held;
      held = 0;
      ncyc = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         ncyc++;
         if (!held && n_sent > 300) begin
            held = 1;
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
         end
         if ((ncyc / 700) % 3 == 2) begin
            rsp_ready = 1'b1;   // calm stretch
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) rsp_ready = 1'b1;
            else if (r < 97) rsp_ready = 1'b0;
            else begin
               rsp_ready = 1'b0;
               repeat ($urandom_range(10, 60)) @(negedge clock);
            end
         end
      end
   end

   // one transaction on the req_ channel; prediction taken at acceptance
   task automatic send_triangle(input triangle_type t, input bit typed,
                                input light_type want, input bit no_gaps);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      tri_drv = t;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      flux_queue.push_back(typed ? want : predict_flux(t, gain_shadow));
      n_sent++;
      @(negedge clock);
   endtask

   // drain the pipe, then write gain while idle
   task automatic set_gain(input logic [GAIN_WIDTH-1:0] g);
      req_valid = 1'b0;
      while (flux_queue.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 8) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = g;
      @(negedge clock);
      csr_wr_en = 1'b0;
      gain_shadow = g;
   endtask

   function automatic logic signed [CW-1:0] small_coord();
      return CW'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int kind;
      kind = $urandom_range(0, 99);
      t = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      if (kind < 55) begin
         // ordinary mesh-sized triangles
         t.ax = small_coord(); t.ay = small_coord(); t.az = small_coord();
         t.bx = small_coord(); t.by = small_coord(); t.bz = small_coord();
         t.cx = small_coord(); t.cy = small_coord(); t.cz = small_coord();
      end else if (kind < 62) begin
         // collapsed: two vertices equal
         t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end else if (kind < 68) begin
         // edge on: ny = 0 from a flat xz projection
         t.bx = t.ax; t.bz = t.az;
      end else if (kind < 75) begin
         // tiny deltas around a far-out point
         t.bx = t.ax + CW'($urandom_range(0, 7)); t.by = t.ay + CW'($urandom_range(0, 7));
         t.bz = t.az - CW'($urandom_range(0, 7)); t.cx = t.ax - CW'($urandom_range(0, 7));
         t.cy = t.ay; t.cz = t.az + CW'($urandom_range(0, 7));
      end
      return t;
   endfunction

   vector_type directed[$];

   function automatic vector_type mk(input triangle_type t, input bit typed,
                                     input logic [FLUX_WIDTH-1:0] f,
                                     input logic [STATUS_WIDTH-1:0] s);
      vector_type v;
      v.shape = t; v.typed = typed; v.want.flux = f; v.want.status = s;
      return v;
   endfunction

   initial begin
      triangle_type t;
      light_type l;
      logic signed [CW-1:0] mx, mn, one, zr;
      int i;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      one = CW'(65536);
      zr = '0;

      // directed table, typed expectations only where obvious
      directed.push_back(mk('0, 1, '0, STATUS_DEGENERATE));
      directed.push_back(mk({9{mx}}, 1, '0, STATUS_DEGENERATE));
      directed.push_back(mk({9{mn}}, 1, '0, STATUS_DEGENERATE));
      directed.push_back(mk({9{CW'(-1)}}, 1, '0, STATUS_DEGENERATE));
      // unit right triangle, up-facing: half area at gain 1.0
      directed.push_back(mk({zr, zr, zr, zr, zr, one, one, zr, zr}, 1, 63'd32768,
                            STATUS_LIT));
      // same triangle wound the other way
      directed.push_back(mk({zr, zr, zr, one, zr, zr, zr, zr, one}, 1, '0,
                            STATUS_FACING_AWAY));
      // vertical triangle, edge on
      directed.push_back(mk({zr, zr, zr, one, zr, zr, zr, one, zr}, 1, '0, STATUS_LIT));
      // extreme spans and tilted triangles, left to the predictor
      directed.push_back(mk({mx, zr, mx, mx, zr, mn, mn, zr, mx}, 0, '0, STATUS_LIT));
      directed.push_back(mk({mn, mn, mn, mn, mx, mx, mx, mn, mn}, 0, '0, STATUS_LIT));
      directed.push_back(mk({mx, mx, mx, mn, mn, mn, mn, mx, mx}, 0, '0, STATUS_LIT));
      directed.push_back(mk({zr, zr, zr, zr, one, one, one, one, zr}, 0, '0, STATUS_LIT));
      directed.push_back(mk({mn, zr, mn, mn, mx, mx, mx, mn, mn}, 0, '0, STATUS_LIT));
      directed.push_back(mk({zr, zr, zr, zr, zr, CW'(1), CW'(1), zr, zr}, 0, '0,
                            STATUS_LIT));
      directed.push_back(mk({CW'(3), CW'(-5), CW'(7), CW'(-2), CW'(9), CW'(4),
                             CW'(6), CW'(1), CW'(-8)}, 0, '0, STATUS_LIT));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k])
         send_triangle(directed[k].shape, directed[k].typed, directed[k].want, 0);

      // gain extremes on every triangle of the directed table
      for (i = 0; i < 3; i++) begin
         set_gain(i == 0 ? '0 : i == 1 ? '1 : GAIN_WIDTH'(1));
         foreach (directed[k]) send_triangle(directed[k].shape, 0, l, 0);
      end

      // random phases across several gain settings
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 270 == 0) begin
            case ((i / 270) % 6)
               0: set_gain(GAIN_RESET);
               1: set_gain('1);
               2: set_gain('0);
               default: set_gain($urandom);
            endcase
         end
         t = random_triangle();
         send_triangle(t, 0, l, (i / 150) % 4 == 3);
      end
      req_valid = 1'b0;

      while (flux_queue.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 20) @(negedge clock);

      $display("covered %0d triangles, %0d responses checked, gains from zero to full scale",
               n_sent, n_checked);
      $display("of those %0d degenerate, %0d facing away and %0d saturated",
               n_degen, n_away, n_sat);
      if (n_errors == 0 && flux_queue.size() == 0) begin
         $display("tb_triangle_facing_light_flux_core passed");
      end else begin
         $display("tb_triangle_facing_light_flux_core failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tfl_pkg.sv
hw/rtl/tfl_mul.sv
hw/rtl/tfl_div.sv
hw/rtl/triangle_facing_light_flux_core.sv
verif/tb_triangle_facing_light_flux_core.sv
